// ----- hdl/assert_macros.svh -----
// assertion macros shared by the lzss decompressor rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/lzss_pkg.sv -----
// package for the lzss byte decompressor: sizes and status codes
// no dependencies
package lzss_pkg;
   localparam int WINDOW_DEPTH = 4096;
   localparam int MAX_OUT_BYTES = 16384;
   localparam int BYTES_PER_RESULT = 8;
   localparam int MIN_MATCH = 3;
   localparam int SIZE_W = 15;
   localparam logic [3:0] LEN_EXT_CODE = 4'd15;
   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_OK = 2'd1;
   localparam logic [1:0] ST_ERR = 2'd2;
endpackage

// ----- hdl/lzss_ram.sv -----
// generic single-port-write, single-read ram with registered read
// no dependencies
module lzss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- hdl/lzss_byte_decompressor_core.sv -----
// lzss byte decompressor top level: token parser, window copy, output packer
// depends on lzss_pkg, lzss_ram, assert_macros.svh
//
// channel  direction  signals
// req      in         req_valid req_ready req_in_byte req_in_last
// rsp      out        rsp_valid rsp_ready rsp_out_bytes rsp_out_count rsp_out_end rsp_status
// csr      in         csr_valid csr_ready csr_expected_out_size
//
// a literal, flag or offset byte puts its result in the rsp register
// a match copies one byte per cycle through the window ram (one read port) while rsp does not stall,
// and it holds the request channel until its copy and the final flush are done
// reset is synchronous; the window keeps its contents across reset and blocks
// rsp stalls hold the copy loop and the request channel
`include "assert_macros.svh"
module lzss_byte_decompressor_core #(
   parameter int WINDOW_DEPTH = lzss_pkg::WINDOW_DEPTH,
   parameter int MAX_OUT_BYTES = lzss_pkg::MAX_OUT_BYTES,
   parameter int BYTES_PER_RESULT = lzss_pkg::BYTES_PER_RESULT,
   parameter int MIN_MATCH = lzss_pkg::MIN_MATCH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_bytes,
   output logic [3:0]  rsp_out_count,
   output logic        rsp_out_end,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [14:0] csr_expected_out_size
);
   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int SW = lzss_pkg::SIZE_W;
   localparam int CW = $clog2(BYTES_PER_RESULT + 1);
   localparam int BW = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;

   localparam logic [2:0] PH_FLAG = 3'd0;
   localparam logic [2:0] PH_TOKEN = 3'd1;
   localparam logic [2:0] PH_HIGH = 3'd2;
   localparam logic [2:0] PH_EXTRA = 3'd3;

   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_COPY = 2'd1;
   localparam logic [1:0] M_FLUSH = 2'd2;

   logic [SW-1:0] target_ff;
   logic [2:0]    phase_ff, phase_in;
   logic [7:0]    flag_ff, flag_in;
   logic [2:0]    tok_ff, tok_in;
   logic [SW-1:0] prod_ff, prod_in;
   logic [7:0]    offlo_ff, offlo_in;
   logic [12:0]   moff_ff, moff_in;
   logic          err_ff, err_in;
   logic [1:0]    mode_ff, mode_in;
   logic [8:0]    left_ff, left_in;
   logic          last_ff, last_in;
   logic          rd_pend_ff, rd_pend_in;

   logic [63:0]   acc_ff, acc_in;
   logic [CW-1:0] acc_cnt_ff, acc_cnt_in;

   logic          ov_ff, ov_in;
   logic [63:0]   ob_ff, ob_in;
   logic [3:0]    oc_ff, oc_in;
   logic          oe_ff, oe_in;
   logic [1:0]    os_ff, os_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data, fwd_ff, fwd_in, src_byte;
   logic          fwd_hit_ff, fwd_hit_in;

   lzss_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_window (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic out_free, accept, big;
   logic [SW:0] len_w;

   assign out_free = !ov_ff || rsp_ready;
   assign req_ready = (mode_ff == M_IDLE) && out_free;
   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign big = {1'b0, target_ff} > (SW+1)'(MAX_OUT_BYTES);
   assign src_byte = fwd_hit_ff ? fwd_ff : rd_data;

   function automatic logic [1:0] stat_of(input logic last, input logic err,
                                          input logic [2:0] ph,
                                          input logic [SW-1:0] pr,
                                          input logic [SW-1:0] tg);
      logic ok;
      ok = !err && (ph == PH_FLAG || ph == PH_TOKEN) && pr == tg;
      if (last) return ok ? lzss_pkg::ST_OK : lzss_pkg::ST_ERR;
      return err ? lzss_pkg::ST_ERR : lzss_pkg::ST_RUN;
   endfunction

   always_comb begin
      logic [2:0] nph;
      logic [2:0] ntok;
      logic [12:0] off;
      logic [8:0] mlen;
      logic start_match;
      logic [7:0] obyte;
      logic put;
      logic [SW-1:0] pnext;
      phase_in = phase_ff; flag_in = flag_ff; tok_in = tok_ff; prod_in = prod_ff;
      offlo_in = offlo_ff; moff_in = moff_ff; err_in = err_ff; mode_in = mode_ff;
      left_in = left_ff; last_in = last_ff; rd_pend_in = 1'b0;
      acc_in = acc_ff; acc_cnt_in = acc_cnt_ff;
      ov_in = ov_ff && !rsp_ready; ob_in = ob_ff; oc_in = oc_ff; oe_in = oe_ff; os_in = os_ff;
      wr_en = 1'b0; wr_addr = prod_ff[AW-1:0]; wr_data = req_in_byte;
      rd_addr = prod_ff[AW-1:0] - moff_ff[AW-1:0];
      fwd_in = fwd_ff; fwd_hit_in = 1'b0;
      nph = PH_TOKEN; ntok = tok_ff + 3'd1;
      if (tok_ff == 3'd7) begin
         nph = PH_FLAG; ntok = 3'd0;
      end
      off = moff_ff; mlen = '0; start_match = 1'b0;
      obyte = 8'd0; put = 1'b0; pnext = prod_ff + SW'(1);
      len_w = '0;
      if (accept) begin
         if (big) err_in = 1'b1;
         if (!(err_ff || big)) begin
            if (prod_ff >= target_ff) begin
               err_in = 1'b1;
            end else begin
               unique case (phase_ff)
                  PH_FLAG: begin
                     flag_in = req_in_byte; tok_in = 3'd0; phase_in = PH_TOKEN;
                  end
                  PH_TOKEN: begin
                     if (!flag_ff[tok_ff]) begin
                        put = 1'b1; obyte = req_in_byte;
                        phase_in = nph; tok_in = ntok;
                     end else begin
                        offlo_in = req_in_byte; phase_in = PH_HIGH;
                     end
                  end
                  PH_HIGH: begin
                     off = {1'b0, req_in_byte[3:0], offlo_ff} + 13'd1;
                     moff_in = off;
                     if (req_in_byte[7:4] == lzss_pkg::LEN_EXT_CODE) begin
                        phase_in = PH_EXTRA;
                     end else begin
                        start_match = 1'b1;
                        mlen = 9'(req_in_byte[7:4]) + 9'(MIN_MATCH);
                     end
                  end
                  default: begin
                     start_match = 1'b1;
                     mlen = 9'(MIN_MATCH) + 9'd15 + 9'(req_in_byte);
                  end
               endcase
            end
         end
         if (start_match) begin
            if ({2'b0, off} > prod_ff) begin
               err_in = 1'b1;
            end else begin
               phase_in = nph; tok_in = ntok;
            end
         end
         if (put) begin
            wr_en = 1'b1; wr_data = obyte; prod_in = pnext;
            acc_in = 64'(obyte); acc_cnt_in = CW'(1);
         end else begin
            acc_in = '0; acc_cnt_in = '0;
         end
         last_in = req_in_last;
         if (start_match && !({2'b0, off} > prod_ff) && mlen != 9'd0) begin
            mode_in = M_COPY; left_in = mlen;
            rd_addr = prod_ff[AW-1:0] - off[AW-1:0];
            rd_pend_in = 1'b1;
         end else begin
            ov_in = 1'b1; ob_in = acc_in; oc_in = 4'(acc_cnt_in); oe_in = 1'b1;
            os_in = stat_of(req_in_last, err_in, phase_in, prod_in, target_ff);
         end
      end else if (mode_ff == M_COPY && out_free) begin
         if (rd_pend_ff) begin
            put = 1'b1; obyte = src_byte;
            wr_en = 1'b1; wr_data = obyte; prod_in = pnext;
            acc_in = acc_ff | (64'(obyte) << (8 * acc_cnt_ff[BW-1:0]));
            if (BYTES_PER_RESULT == 1) acc_in = 64'(obyte);
            acc_cnt_in = acc_cnt_ff + CW'(1);
            left_in = left_ff - 9'd1;
            if (left_in == 9'd0 || pnext >= target_ff) begin
               mode_in = M_FLUSH;
            end else begin
               rd_addr = pnext[AW-1:0] - moff_ff[AW-1:0];
               rd_pend_in = 1'b1;
               fwd_hit_in = (moff_ff == 13'd1);
               fwd_in = obyte;
               if (acc_cnt_in == CW'(BYTES_PER_RESULT)) begin
                  // every result of the match carries the status of its final one
                  len_w = {1'b0, pnext} + (SW+1)'(left_in);
                  ov_in = 1'b1; ob_in = acc_in; oc_in = 4'(acc_cnt_in); oe_in = 1'b0;
                  os_in = stat_of(last_ff, err_ff, phase_ff,
                                  (len_w >= {1'b0, target_ff}) ? target_ff : pnext,
                                  target_ff);
                  acc_in = '0; acc_cnt_in = '0;
               end
            end
         end else begin
            rd_pend_in = 1'b1;
         end
      end else if (mode_ff == M_FLUSH && out_free) begin
         mode_in = M_IDLE;
         ov_in = 1'b1; ob_in = acc_ff; oc_in = 4'(acc_cnt_ff); oe_in = 1'b1;
         os_in = stat_of(last_ff, err_ff, phase_ff, prod_ff, target_ff);
         acc_in = '0; acc_cnt_in = '0;
      end else if (mode_ff == M_COPY) begin
         rd_pend_in = rd_pend_ff;
         rd_addr = prod_ff[AW-1:0] - moff_ff[AW-1:0];
         fwd_hit_in = fwd_hit_ff;
         if (rd_pend_ff) rd_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0; phase_ff <= PH_FLAG; flag_ff <= '0; tok_ff <= '0;
         prod_ff <= '0; offlo_ff <= '0; moff_ff <= '0; err_ff <= 1'b0;
         mode_ff <= M_IDLE; left_ff <= '0; last_ff <= 1'b0; rd_pend_ff <= 1'b0;
         acc_cnt_ff <= '0; ov_ff <= 1'b0; fwd_hit_ff <= 1'b0;
      end else begin
         if (csr_valid) target_ff <= csr_expected_out_size;
         mode_ff <= mode_in; left_ff <= left_in; last_ff <= last_in;
         rd_pend_ff <= rd_pend_in; acc_cnt_ff <= acc_cnt_in; ov_ff <= ov_in;
         fwd_hit_ff <= fwd_hit_in;
         if ((accept && req_in_last && mode_in == M_IDLE) ||
             (mode_ff == M_FLUSH && out_free && last_ff)) begin
            phase_ff <= PH_FLAG; flag_ff <= '0; tok_ff <= '0; prod_ff <= '0;
            offlo_ff <= '0; moff_ff <= '0; err_ff <= 1'b0;
         end else begin
            phase_ff <= phase_in; flag_ff <= flag_in; tok_ff <= tok_in;
            prod_ff <= prod_in;
            offlo_ff <= offlo_in; moff_ff <= moff_in; err_ff <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; ob_ff <= ob_in; oc_ff <= oc_in; oe_ff <= oe_in; os_ff <= os_in;
      fwd_ff <= fwd_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_out_bytes = ob_ff;
   assign rsp_out_count = oc_ff;
   assign rsp_out_end = oe_ff;
   assign rsp_status = os_ff;

   `ASSERT_IMPL(a_no_req_in_copy, clock, reset, mode_ff != M_IDLE, !req_ready, "req in copy")
   `ASSERT_IMPL(a_count_range, clock, reset, rsp_valid,
                rsp_out_count <= 4'(BYTES_PER_RESULT), "count range")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
endmodule
